### rtl/core/lsc_pkg.sv
// Shared types, constants and outcode helper for the line segment clipper.
package lsc_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int MAX_MOVES  = 4;
  localparam int ADDR_BITS  = 4;

  localparam logic [3:0] OC_LEFT   = 4'd1;
  localparam logic [3:0] OC_RIGHT  = 4'd2;
  localparam logic [3:0] OC_BOTTOM = 4'd4;
  localparam logic [3:0] OC_TOP    = 4'd8;

  // Register byte addresses
  localparam logic [ADDR_BITS-1:0] REG_X_MIN = 4'h0;
  localparam logic [ADDR_BITS-1:0] REG_Y_MIN = 4'h4;
  localparam logic [ADDR_BITS-1:0] REG_X_MAX = 4'h8;
  localparam logic [ADDR_BITS-1:0] REG_Y_MAX = 4'hC;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x_min;
    coord_t y_min;
    coord_t x_max;
    coord_t y_max;
  } window_t;

  // Segment state carried between clipping rounds
  typedef struct packed {
    logic   done;
    logic   accept;
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } seg_t;

  function automatic logic [3:0] outcode(coord_t x, coord_t y, window_t w);
    logic [3:0] c;
    c = '0;
    if (x < w.x_min) c |= OC_LEFT;
    else if (x > w.x_max) c |= OC_RIGHT;
    if (y < w.y_min) c |= OC_BOTTOM;
    else if (y > w.y_max) c |= OC_TOP;
    return c;
  endfunction

endpackage

### rtl/core/lsc_divider.sv
// Pipelined restoring divider: unsigned dividend by divisor, one quotient bit per stage.
module lsc_divider (
  input  logic                            clk,
  input  logic                            en,
  input  logic [lsc_pkg::PROD_BITS-1:0]   dividend,
  input  logic [lsc_pkg::DIFF_BITS-1:0]   divisor,
  output logic [lsc_pkg::PROD_BITS-1:0]   quotient
);
  localparam int NB = lsc_pkg::PROD_BITS;
  localparam int DB = lsc_pkg::DIFF_BITS;

  logic [DB:0]   rem_r [NB+1];
  logic [NB-1:0] num_r [NB+1];
  logic [NB-1:0] quo_r [NB+1];
  logic [DB-1:0] den_r [NB+1];

  always_comb begin
    rem_r[0] = '0;
    num_r[0] = dividend;
    quo_r[0] = '0;
    den_r[0] = divisor;
  end

  // One stage per quotient bit, MSB first
  for (genvar i = 0; i < NB; i++) begin : g_stage
    logic [DB:0] sh;
    logic [DB:0] df;
    logic [DB:0] rem_nxt;
    logic [NB-1:0] quo_nxt;
    always_comb begin
      sh = {rem_r[i][DB-1:0], num_r[i][NB-1]};
      df = sh - {1'b0, den_r[i]};
      if (sh >= {1'b0, den_r[i]}) begin
        rem_nxt = df;
        quo_nxt = {quo_r[i][NB-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        quo_nxt = {quo_r[i][NB-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= rem_nxt;
        num_r[i+1] <= {num_r[i][NB-2:0], 1'b0};
        quo_r[i+1] <= quo_nxt;
        den_r[i+1] <= den_r[i];
      end
    end
  end

  assign quotient = (den_r[NB] == '0) ? '0 : quo_r[NB];
endmodule

### rtl/core/lsc_round.sv
// One clipping round: outcode test, multiply, pipelined divide, endpoint move.
module lsc_round (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  lsc_pkg::window_t  win,
  input  logic              in_vld,
  input  lsc_pkg::seg_t     seg_in,
  input  logic              last,
  output logic              out_vld,
  output lsc_pkg::seg_t     seg_out
);
  localparam int DB = lsc_pkg::DIFF_BITS;
  localparam int PB = lsc_pkg::PROD_BITS;
  // Operand register, product register, then PB divider stages
  localparam int DEPTH = PB + 2;

  // Stage A: classify and form signed operands
  logic [3:0] c0, c1, co;
  logic signed [DB-1:0] a_s, b_s, c_s;
  logic signed [DB-1:0] base_d;
  lsc_pkg::coord_t edge_d;
  logic is_y, do_move, acc_now, rej_now;

  always_comb begin
    c0 = lsc_pkg::outcode(seg_in.x0, seg_in.y0, win);
    c1 = lsc_pkg::outcode(seg_in.x1, seg_in.y1, win);
    co = (c0 != '0) ? c0 : c1;
    acc_now = ((c0 | c1) == '0);
    rej_now = ((c0 & c1) != '0) || last;
    do_move = !seg_in.done && !acc_now && !rej_now;
    is_y = (co & (lsc_pkg::OC_TOP | lsc_pkg::OC_BOTTOM)) != '0;
    if ((co & lsc_pkg::OC_TOP) != '0) edge_d = win.y_max;
    else if ((co & lsc_pkg::OC_BOTTOM) != '0) edge_d = win.y_min;
    else if ((co & lsc_pkg::OC_RIGHT) != '0) edge_d = win.x_max;
    else edge_d = win.x_min;
    // Differences of two coordinates always fit one extra bit
    if (is_y) begin
      a_s = DB'(seg_in.x1) - DB'(seg_in.x0);
      b_s = DB'(edge_d) - DB'(seg_in.y0);
      c_s = DB'(seg_in.y1) - DB'(seg_in.y0);
      base_d = DB'(seg_in.x0);
    end else begin
      a_s = DB'(seg_in.y1) - DB'(seg_in.y0);
      b_s = DB'(edge_d) - DB'(seg_in.x0);
      c_s = DB'(seg_in.x1) - DB'(seg_in.x0);
      base_d = DB'(seg_in.y0);
    end
  end

  logic [DB-1:0] ua_r, ub_r, uc_r;

  // Side-band pipeline carrying the segment through the divider
  typedef struct packed {
    lsc_pkg::seg_t   seg;
    logic            move;
    logic            first;
    logic            is_y;
    lsc_pkg::coord_t edge_v;
    lsc_pkg::coord_t base;
    logic            neg;
  } side_t;

  side_t side_r [DEPTH];
  logic  vld_r  [DEPTH];
  side_t s0;

  always_comb begin
    s0.seg = seg_in;
    if (!seg_in.done && acc_now) begin
      s0.seg.done = 1'b1;
      s0.seg.accept = 1'b1;
    end else if (!seg_in.done && rej_now) begin
      s0.seg.done = 1'b1;
      s0.seg.accept = 1'b0;
    end
    s0.move = do_move;
    s0.first = (c0 != '0);
    s0.is_y = is_y;
    s0.edge_v = edge_d;
    s0.base = lsc_pkg::coord_t'(base_d);
    s0.neg = (a_s < 0) ^ (b_s < 0) ^ (c_s < 0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ua_r <= a_s[DB-1] ? DB'(-a_s) : DB'(a_s);
      ub_r <= b_s[DB-1] ? DB'(-b_s) : DB'(b_s);
      uc_r <= c_s[DB-1] ? DB'(-c_s) : DB'(c_s);
    end
  end

  // Stage B: magnitude product
  logic [PB-1:0] prod_r;
  logic [DB-1:0] den_r;
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= ua_r * ub_r;
      den_r  <= uc_r;
    end
  end

  logic [PB-1:0] quo;
  lsc_divider u_div (
    .clk(clk), .en(en), .dividend(prod_r), .divisor(den_r), .quotient(quo)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) side_r[i] <= (i == 0) ? s0 : side_r[(i == 0) ? 0 : i-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i] <= 1'b0;
      else if (en) vld_r[i] <= (i == 0) ? in_vld : vld_r[(i == 0) ? 0 : i-1];
    end
  end

  // Final: apply the move
  side_t sf;
  lsc_pkg::coord_t nc;
  always_comb begin
    sf = side_r[DEPTH-1];
    nc = sf.base + (sf.neg ? lsc_pkg::coord_t'(-quo) : lsc_pkg::coord_t'(quo));
    seg_out = sf.seg;
    if (sf.move) begin
      if (sf.first) begin
        seg_out.x0 = sf.is_y ? nc : sf.edge_v;
        seg_out.y0 = sf.is_y ? sf.edge_v : nc;
      end else begin
        seg_out.x1 = sf.is_y ? nc : sf.edge_v;
        seg_out.y1 = sf.is_y ? sf.edge_v : nc;
      end
    end
  end
  assign out_vld = vld_r[DEPTH-1];
endmodule

### rtl/core/line_segment_clipper.sv
// Cohen-Sutherland segment clipper: four cascaded rounds plus a final test.
// Pipeline: 5 rounds of (PROD_BITS+2) = 36 stages each, then the output register.
// Throughput: one segment per cycle; the whole pipe stalls when the output is held.
// Reset (rst_n low, synchronous) clears valid bits; window returns to 0..1023.
// Payload registers are not reset.
module line_segment_clipper (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [lsc_pkg::ADDR_BITS-1:0]    cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lsc_pkg::coord_t                  in_start_x,
  input  lsc_pkg::coord_t                  in_start_y,
  input  lsc_pkg::coord_t                  in_end_x,
  input  lsc_pkg::coord_t                  in_end_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_accepted,
  output lsc_pkg::coord_t                  out_clipped_start_x,
  output lsc_pkg::coord_t                  out_clipped_start_y,
  output lsc_pkg::coord_t                  out_clipped_end_x,
  output lsc_pkg::coord_t                  out_clipped_end_y
);
  localparam int CB = lsc_pkg::COORD_BITS;
  localparam int NR = lsc_pkg::MAX_MOVES + 1;

  // Configuration registers
  lsc_pkg::window_t win_r;
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.x_min <= '0;
      win_r.y_min <= '0;
      win_r.x_max <= CB'(1023);
      win_r.y_max <= CB'(1023);
    end else if (cfg_wr) begin
      case (cfg_paddr)
        lsc_pkg::REG_X_MIN: win_r.x_min <= cfg_pwdata[CB-1:0];
        lsc_pkg::REG_Y_MIN: win_r.y_min <= cfg_pwdata[CB-1:0];
        lsc_pkg::REG_X_MAX: win_r.x_max <= cfg_pwdata[CB-1:0];
        lsc_pkg::REG_Y_MAX: win_r.y_max <= cfg_pwdata[CB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      lsc_pkg::REG_X_MIN: cfg_prdata = 32'($signed(win_r.x_min));
      lsc_pkg::REG_Y_MIN: cfg_prdata = 32'($signed(win_r.y_min));
      lsc_pkg::REG_X_MAX: cfg_prdata = 32'($signed(win_r.x_max));
      lsc_pkg::REG_Y_MAX: cfg_prdata = 32'($signed(win_r.y_max));
      default: cfg_prdata = '0;
    endcase
  end

  // Global stall: advance whenever the output register is free
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  lsc_pkg::seg_t seg   [NR+1];
  logic          vld   [NR+1];

  always_comb begin
    seg[0].done   = 1'b0;
    seg[0].accept = 1'b0;
    seg[0].x0 = in_start_x;
    seg[0].y0 = in_start_y;
    seg[0].x1 = in_end_x;
    seg[0].y1 = in_end_y;
    vld[0] = in_valid;
  end

  // Four move rounds, then a round that only classifies (no move allowed)
  for (genvar r = 0; r < NR; r++) begin : g_round
    lsc_round u_round (
      .clk(clk), .rst_n(rst_n), .en(en), .win(win_r),
      .in_vld(vld[r]), .seg_in(seg[r]), .last(r == NR-1),
      .out_vld(vld[r+1]), .seg_out(seg[r+1])
    );
  end

  // Output register
  logic          out_valid_r;
  lsc_pkg::seg_t res_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= vld[NR];
  end
  always_ff @(posedge clk) begin
    if (en) res_r <= seg[NR];
  end

  assign out_valid           = out_valid_r;
  assign out_accepted        = res_r.accept;
  assign out_clipped_start_x = res_r.accept ? res_r.x0 : '0;
  assign out_clipped_start_y = res_r.accept ? res_r.y0 : '0;
  assign out_clipped_end_x   = res_r.accept ? res_r.x1 : '0;
  assign out_clipped_end_y   = res_r.accept ? res_r.y1 : '0;

  // A held beat stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(res_r))
    else $error("output beat changed while stalled");
  // Result is always settled
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> res_r.done)
    else $error("segment left pipe undecided");
  a_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_clipped_start_x == '0 && out_clipped_end_y == '0)
    else $error("rejected beat has nonzero coordinates");
endmodule
